[hdl/msadpcm_pkg.sv]
package msadpcm_pkg;

   localparam int NUM_COEF_PAIRS = 8;
   localparam int COEF_AW = (NUM_COEF_PAIRS > 1) ? $clog2(NUM_COEF_PAIRS) : 1;

   localparam int ADAPT_W = 10;
   localparam logic [15:0] DELTA_FLOOR = 16'd16;
   localparam logic [15:0] SPB_MIN = 16'd2;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_DATA   = 2'd1,
      OP_COEF   = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      CSR_STEREO = 1'b0,
      CSR_SPB    = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_READ,
      ST_COEF,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               channel;
      logic [2:0]         predictor_index;
      logic [15:0]        initial_delta;
      logic signed [15:0] initial_newer;
      logic signed [15:0] initial_older;
      logic [7:0]         data_byte;
      logic signed [15:0] coef_first;
      logic signed [15:0] coef_second;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               sample_channel;
      logic               last_of_item;
      logic               block_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         predictor;
      logic [15:0]        delta;
      logic signed [15:0] newer;
      logic signed [15:0] older;
   } chan_state_type;

   // step size scale factors, x256
   function automatic logic [ADAPT_W-1:0] adapt_step(input logic [3:0] nib);
      logic [ADAPT_W-1:0] f;
      case (nib)
         4'd4, 4'd12:  f = ADAPT_W'(307);
         4'd5, 4'd11:  f = ADAPT_W'(409);
         4'd6, 4'd10:  f = ADAPT_W'(512);
         4'd7, 4'd9:   f = ADAPT_W'(614);
         4'd8:         f = ADAPT_W'(768);
         default:      f = ADAPT_W'(230);
      endcase
      return f;
   endfunction

endpackage

[hdl/ms_adpcm_block_decoder.sv]
// Microsoft ADPCM block decoder, mono or stereo. Load coefficient pairs with
// coefficient-write transactions first, then send one header per channel
// (the channel 1 header starts a stereo block) followed by data bytes. A
// block-starting header emits its history samples (2 mono, 4 stereo). Each
// nibble of a data byte is a read-modify-write of the channel state memory
// through a coefficient memory read and one shared 16x16 multiplier used
// twice, stepping through the COEF, MUL1, MUL2, SUM and OUT states, with
// ST_READ before each later nibble. Output stalls hold the decoder until the
// result register is free; the result register lets the next transaction be
// accepted while the last sample still waits.
module ms_adpcm_block_decoder
   import msadpcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration and block control
   logic        stereo_ff;
   logic [15:0] spb_ff;
   logic [15:0] frames_left_ff, frames_left_in;

   state_type   state_ff, state_in;
   req_type     item_ff;
   logic [1:0]  emit_idx_ff, emit_idx_in;
   logic        nib_idx_ff, nib_idx_in;

   // memories
   chan_state_type       chan_mem [2];
   logic [1:0]           chan_vld_ff;
   chan_state_type       chan_rd_ff;
   logic                 chan_rd_vld_ff;
   logic [31:0]          coef_mem [NUM_COEF_PAIRS];
   logic [31:0]          coef_rd_ff;
   logic                 coef_ok_ff;

   logic                 chan_we, chan_re, coef_we, coef_re;
   logic                 chan_waddr, chan_raddr;
   chan_state_type       chan_wdata;

   // datapath
   logic signed [31:0]   prod1_ff, prod2_ff;
   logic signed [24:0]   pred_ff;
   logic signed [20:0]   dcode_ff;
   logic [15:0]          nd_ff;

   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_load, rsp_free;

   logic                 accept, hdr_start, data_start, item_write;
   logic                 cur_ch;
   logic [3:0]           nib;
   chan_state_type       cs_eff;
   logic signed [15:0]   coef1, coef2, mul_a, mul_b;
   logic signed [31:0]   mul_out;
   logic [25:0]          nd_prod;
   logic [17:0]          nd_scaled;
   logic signed [20:0]   dcode_in;
   logic signed [32:0]   psum, psum_adj;
   logic signed [25:0]   ns_sum;
   logic signed [15:0]   ns;
   logic [15:0]          spb_eff;
   logic [15:0]          fl_dec;
   logic                 dec_now, nib_last;
   logic                 hdr_ch, hdr_newer, hdr_last;
   logic signed [15:0]   hdr_sample;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cs_eff  = chan_rd_vld_ff ? chan_rd_ff : '0;
   assign cur_ch  = stereo_ff && nib_idx_ff;
   assign nib     = nib_idx_ff ? item_ff.data_byte[3:0] : item_ff.data_byte[7:4];
   assign spb_eff = (spb_ff < SPB_MIN) ? SPB_MIN : spb_ff;

   assign hdr_start  = (req_data.op == OP_HEADER) &&
                       (stereo_ff ? req_data.channel : !req_data.channel);
   assign item_write = (req_data.op == OP_HEADER) && (stereo_ff || !req_data.channel);
   assign data_start = (req_data.op == OP_DATA) && (frames_left_ff != 16'd0);

   // arithmetic
   assign coef1 = coef_ok_ff ? $signed(coef_rd_ff[15:0])  : 16'sd0;
   assign coef2 = coef_ok_ff ? $signed(coef_rd_ff[31:16]) : 16'sd0;
   assign mul_a = (state_ff == ST_MUL1) ? cs_eff.newer : cs_eff.older;
   assign mul_b = (state_ff == ST_MUL1) ? coef1 : coef2;
   assign mul_out = mul_a * mul_b;

   assign nd_prod   = 26'(cs_eff.delta) * 26'(adapt_step(nib));
   assign nd_scaled = nd_prod[25:8];
   assign dcode_in  = $signed({1'b0, cs_eff.delta}) * $signed(nib);

   // truncate toward zero: bias negative sums before the shift
   assign psum     = {prod1_ff[31], prod1_ff} + {prod2_ff[31], prod2_ff};
   assign psum_adj = psum + (psum[32] ? 33'sd255 : 33'sd0);

   assign ns_sum = {pred_ff[24], pred_ff} + {{5{dcode_ff[20]}}, dcode_ff};
   always_comb begin
      if (ns_sum < -26'sd32767) begin
         ns = -16'sd32767;
      end else if (ns_sum > 26'sd32767) begin
         ns = 16'sd32767;
      end else begin
         ns = ns_sum[15:0];
      end
   end

   assign dec_now  = !stereo_ff || nib_idx_ff;
   assign fl_dec   = dec_now ? frames_left_ff - 16'd1 : frames_left_ff;
   assign nib_last = nib_idx_ff || (!stereo_ff && fl_dec == 16'd0);

   // header emission order: older of each channel, then newer of each channel
   assign hdr_ch     = stereo_ff && emit_idx_ff[0];
   assign hdr_newer  = stereo_ff ? emit_idx_ff[1] : emit_idx_ff[0];
   assign hdr_last   = stereo_ff ? (emit_idx_ff == 2'd3) : (emit_idx_ff == 2'd1);
   always_comb begin
      if (hdr_ch == item_ff.channel) begin
         hdr_sample = hdr_newer ? item_ff.initial_newer : item_ff.initial_older;
      end else begin
         hdr_sample = hdr_newer ? cs_eff.newer : cs_eff.older;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && hdr_start) begin
               state_in = ST_HDR;
            end else if (accept && data_start) begin
               state_in = ST_COEF;
            end
         end
         ST_HDR: begin
            if (rsp_free && hdr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_COEF;
         ST_COEF: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_free) begin
               state_in = nib_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and control
   always_comb begin
      req_ready      = 1'b0;
      chan_we        = 1'b0;
      chan_waddr     = 1'b0;
      chan_wdata     = '0;
      chan_re        = 1'b0;
      chan_raddr     = 1'b0;
      coef_we        = 1'b0;
      coef_re        = 1'b0;
      rsp_load       = 1'b0;
      rsp_in         = '0;
      frames_left_in = frames_left_ff;
      emit_idx_in    = emit_idx_ff;
      nib_idx_in     = nib_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            emit_idx_in = 2'd0;
            nib_idx_in  = 1'b0;
            if (accept) begin
               // channel 0 state feeds both a stereo header and a data byte
               chan_re    = 1'b1;
               chan_raddr = 1'b0;
               coef_we    = (req_data.op == OP_COEF) &&
                            (int'(req_data.predictor_index) < NUM_COEF_PAIRS);
               chan_we    = item_write;
               chan_waddr = req_data.channel;
               chan_wdata = '{predictor: req_data.predictor_index,
                              delta:     req_data.initial_delta,
                              newer:     req_data.initial_newer,
                              older:     req_data.initial_older};
               if (hdr_start) begin
                  frames_left_in = spb_eff - SPB_MIN;
               end
            end
         end
         ST_HDR: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_in      = '{pcm_sample:     hdr_sample,
                               sample_channel: hdr_ch,
                               last_of_item:   hdr_last,
                               block_done:     hdr_last && (frames_left_ff == 16'd0)};
               emit_idx_in = emit_idx_ff + 2'd1;
            end
         end
         ST_READ: begin
            chan_re    = 1'b1;
            chan_raddr = cur_ch;
         end
         ST_COEF: begin
            coef_re = 1'b1;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load       = 1'b1;
               rsp_in         = '{pcm_sample:     ns,
                                  sample_channel: cur_ch,
                                  last_of_item:   nib_last,
                                  block_done:     dec_now && (fl_dec == 16'd0)};
               chan_we        = 1'b1;
               chan_waddr     = cur_ch;
               chan_wdata     = '{predictor: cs_eff.predictor,
                                  delta:     nd_ff,
                                  newer:     ns,
                                  older:     cs_eff.newer};
               frames_left_in = fl_dec;
               nib_idx_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_mem[chan_waddr] <= chan_wdata;
      end
      if (chan_re) begin
         chan_rd_ff     <= chan_mem[chan_raddr];
         chan_rd_vld_ff <= chan_vld_ff[chan_raddr];
      end
      if (coef_we) begin
         coef_mem[COEF_AW'(req_data.predictor_index)] <=
            {req_data.coef_second, req_data.coef_first};
      end
      if (coef_re) begin
         coef_rd_ff <= coef_mem[COEF_AW'(cs_eff.predictor)];
         coef_ok_ff <= int'(cs_eff.predictor) < NUM_COEF_PAIRS;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_COEF) begin
         nd_ff <= (nd_scaled < 18'(DELTA_FLOOR)) ? DELTA_FLOOR : nd_scaled[15:0];
      end
      if (state_ff == ST_MUL1) begin
         prod1_ff <= mul_out;
      end
      if (state_ff == ST_MUL2) begin
         prod2_ff <= mul_out;
         dcode_ff <= dcode_in;
      end
      if (state_ff == ST_SUM) begin
         pred_ff <= psum_adj[32:8];
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      emit_idx_ff <= emit_idx_in;
      nib_idx_ff  <= nib_idx_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         frames_left_ff <= 16'd0;
         chan_vld_ff    <= 2'b00;
         stereo_ff      <= 1'b0;
         spb_ff         <= SPB_MIN;
      end else begin
         state_ff       <= state_in;
         frames_left_ff <= frames_left_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (chan_we) begin
            chan_vld_ff[chan_waddr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_STEREO: stereo_ff <= csr_data[0];
               CSR_SPB:    spb_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

[sim/tb_top.sv]
module tb_top
   import msadpcm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   class pcm_tracker;
      bit          stereo_mode;
      logic [15:0] frames_per_block;
      logic [31:0] coef_pair [NUM_COEF_PAIRS];
      logic [2:0]  slot [2];
      logic [15:0] step [2];
      logic [15:0] newer [2];
      logic [15:0] older [2];
      logic [15:0] frames_left;
      int unsigned adapt_scale [16];
      rsp_type     pending_pcm [$];
      int          bad_count;
      int          decoded_items;

      function new();
         adapt_scale = '{230, 230, 230, 230, 307, 409, 512, 614,
                         768, 614, 512, 409, 307, 230, 230, 230};
         foreach (coef_pair[i]) coef_pair[i] = '0;
         for (int c = 0; c < 2; c++) begin
            slot[c]  = '0;
            step[c]  = '0;
            newer[c] = '0;
            older[c] = '0;
         end
         frames_left      = '0;
         stereo_mode      = 1'b0;
         frames_per_block = 16'd2;
         bad_count        = 0;
         decoded_items    = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [15:0] value);
         if (idx == CSR_STEREO) stereo_mode = value[0];
         else frames_per_block = value;
      endfunction

      function void push_sample(logic [15:0] value, bit ch, bit done);
         rsp_type s;
         s.pcm_sample     = value;
         s.sample_channel = ch;
         s.last_of_item   = 1'b0;
         s.block_done     = done;
         pending_pcm.push_back(s);
      endfunction

      // One nibble through prediction, clamp and step-size adaptation.
      function logic [15:0] step_channel(bit ch, logic [3:0] code_bits);
         logic [31:0] pair;
         longint      c1, c2, hist_new, hist_old, pred, code, delta, sample;
         int unsigned scaled;
         pair     = coef_pair[slot[ch]];
         c1       = $signed(pair[15:0]);
         c2       = $signed(pair[31:16]);
         hist_new = $signed(newer[ch]);
         hist_old = $signed(older[ch]);
         pred     = (hist_new * c1 + hist_old * c2) / 256;
         code     = code_bits;
         if (code_bits[3]) code -= 16;
         delta    = step[ch];
         sample   = pred + delta * code;
         if (sample < -32767) sample = -32767;
         else if (sample > 32767) sample = 32767;
         scaled = step[ch];
         scaled = scaled * adapt_scale[code_bits] / 256;
         if (scaled < 16) scaled = 16;
         step[ch]  = scaled[15:0];
         older[ch] = newer[ch];
         newer[ch] = sample[15:0];
         return newer[ch];
      endfunction

      function void accept_item(req_type r);
         int          first;
         int          nch;
         rsp_type     tail;
         logic [15:0] left, right;
         first = pending_pcm.size();
         nch   = stereo_mode ? 2 : 1;
         case (r.op)
            OP_COEF: begin
               coef_pair[r.predictor_index] = {r.coef_second, r.coef_first};
               decoded_items++;
            end
            OP_HEADER: begin
               if (stereo_mode || !r.channel) begin
                  slot[r.channel]  = r.predictor_index;
                  step[r.channel]  = r.initial_delta;
                  newer[r.channel] = r.initial_newer;
                  older[r.channel] = r.initial_older;
                  // only the last channel's header opens the block
                  if (!stereo_mode || r.channel) begin
                     frames_left = (frames_per_block < 16'd2) ? 16'd0
                                                             : frames_per_block - 16'd2;
                     for (int c = 0; c < nch; c++) push_sample(older[c], c[0], 1'b0);
                     for (int c = 0; c < nch; c++)
                        push_sample(newer[c], c[0], (c == nch - 1) && (frames_left == 0));
                  end
               end
            end
            OP_DATA: begin
               if (frames_left != 0) begin
                  if (stereo_mode) begin
                     left  = step_channel(1'b0, r.data_byte[7:4]);
                     right = step_channel(1'b1, r.data_byte[3:0]);
                     frames_left--;
                     push_sample(left, 1'b0, 1'b0);
                     push_sample(right, 1'b1, frames_left == 0);
                  end else begin
                     left = step_channel(1'b0, r.data_byte[7:4]);
                     frames_left--;
                     push_sample(left, 1'b0, frames_left == 0);
                     // drop the low nibble past the last frame
                     if (frames_left != 0) begin
                        right = step_channel(1'b0, r.data_byte[3:0]);
                        frames_left--;
                        push_sample(right, 1'b0, frames_left == 0);
                     end
                  end
               end
            end
            default: ;
         endcase
         if (pending_pcm.size() > first) begin
            tail = pending_pcm.pop_back();
            tail.last_of_item = 1'b1;
            pending_pcm.push_back(tail);
            decoded_items++;
         end
      endfunction

      function void check_sample(rsp_type got);
         rsp_type want;
         if (pending_pcm.size() == 0) begin
            $error("sample %0d on channel %0d with nothing pending",
                   got.pcm_sample, got.sample_channel);
            bad_count++;
            return;
         end
         want = pending_pcm.pop_front();
         if (got.pcm_sample !== want.pcm_sample) begin
            $error("pcm_sample: expected %0d, got %0d", want.pcm_sample, got.pcm_sample);
            bad_count++;
         end
         if (got.sample_channel !== want.sample_channel) begin
            $error("sample_channel: expected %0d, got %0d",
                   want.sample_channel, got.sample_channel);
            bad_count++;
         end
         if (got.last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d",
                   want.last_of_item, got.last_of_item);
            bad_count++;
         end
         if (got.block_done !== want.block_done) begin
            $error("block_done: expected %0d, got %0d", want.block_done, got.block_done);
            bad_count++;
         end
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          ITEM_TARGET   = 500;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          LONG_HOLD     = 400;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;

   pcm_tracker  tracker;
   int unsigned cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          hold_armed = 1'b0;
   bit          cur_stereo = 1'b0;
   logic [15:0] cur_frames = 16'd2;

   ms_adpcm_block_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int idle_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] std_pair(int k);
      case (k)
         0:       return {16'sd0, 16'sd256};
         1:       return {-16'sd256, 16'sd512};
         2:       return {16'sd0, 16'sd0};
         3:       return {16'sd64, 16'sd192};
         4:       return {16'sd0, 16'sd240};
         5:       return {-16'sd208, 16'sd460};
         default: return {-16'sd232, 16'sd392};
      endcase
   endfunction

   // Fields the op does not use still carry random bits.
   function automatic req_type make_item(logic [1:0] op);
      req_type r;
      r.op              = op;
      r.channel         = 1'($urandom);
      r.predictor_index = 3'($urandom);
      r.initial_delta   = 16'($urandom);
      r.initial_newer   = 16'($urandom);
      r.initial_older   = 16'($urandom);
      r.data_byte       = 8'($urandom);
      r.coef_first      = 16'($urandom);
      r.coef_second     = 16'($urandom);
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) tracker.accept_item(req_data);
         if (rsp_valid && rsp_ready) tracker.check_sample(rsp_data);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         else if (hold_armed) begin
            hold_armed = 1'b0;
            stall_left = LONG_HOLD;
         end else stall_left = idle_gap(rsp_idle_pct);
         rsp_ready <= !reset && stall_left == 0;
      end
   end

   task automatic send_item(req_type item);
      int gap;
      gap = idle_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_coef(logic [2:0] idx, logic [31:0] pair);
      req_type r;
      r = make_item(OP_COEF);
      r.predictor_index = idx;
      r.coef_first      = pair[15:0];
      r.coef_second     = pair[31:16];
      send_item(r);
   endtask

   task automatic send_header(bit ch, logic [2:0] idx, logic [15:0] delta,
                              logic [15:0] hist_new, logic [15:0] hist_old);
      req_type r;
      r = make_item(OP_HEADER);
      r.channel         = ch;
      r.predictor_index = idx;
      r.initial_delta   = delta;
      r.initial_newer   = hist_new;
      r.initial_older   = hist_old;
      send_item(r);
   endtask

   task automatic send_data(logic [7:0] codes);
      req_type r;
      r = make_item(OP_DATA);
      r.data_byte = codes;
      send_item(r);
   endtask

   task automatic send_random_header(bit ch);
      logic [15:0] delta, hist_new, hist_old;
      delta    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 1024));
      hist_new = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 4000)) - 16'd2000;
      hist_old = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 4000)) - 16'd2000;
      send_header(ch, 3'($urandom), delta, hist_new, hist_old);
   endtask

   task automatic set_mode(bit stereo, logic [15:0] frames);
      csr_valid <= 1'b1;
      csr_index <= CSR_STEREO;
      csr_data  <= {15'd0, stereo};
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(CSR_STEREO, {15'd0, stereo});
      csr_index <= CSR_SPB;
      csr_data  <= frames;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(CSR_SPB, frames);
      csr_valid <= 1'b0;
      cur_stereo = stereo;
      cur_frames = frames;
   endtask

   // Wait out every pending sample, then let trailing no-result work finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_pcm.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_block();
      int frames;
      int bytes;
      if ($urandom_range(0, 3) == 0)
         send_coef(3'($urandom), ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                                           : std_pair($urandom_range(0, 6)));
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       send_item(make_item(OP_UNUSED));
            1:       send_random_header(1'b1);
            default: send_data(8'($urandom));
         endcase
      end
      if (cur_stereo) begin
         // now and then skip the left header
         if ($urandom_range(0, 7) != 0) send_random_header(1'b0);
         send_random_header(1'b1);
      end else send_random_header(1'b0);
      frames = (cur_frames < 16'd2) ? 0 : int'(cur_frames) - 2;
      bytes  = cur_stereo ? frames : (frames + 1) / 2;
      if (bytes > 40) bytes = $urandom_range(20, 40);
      if (bytes > 0 && $urandom_range(0, 4) == 0) bytes = $urandom_range(0, bytes - 1);
      else if ($urandom_range(0, 4) == 0) bytes++;
      repeat (bytes) send_data(8'($urandom));
   endtask

   initial begin
      tracker = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_STEREO;
      csr_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mono, odd block length so the last low nibble is dropped
      set_mode(1'b0, 16'd5);
      for (int k = 0; k < 7; k++) send_coef(3'(k), std_pair(k));
      send_coef(3'd7, {16'h8000, 16'h7FFF});
      send_item(make_item(OP_UNUSED));
      send_data(8'h5A);
      send_header(1'b1, 3'd0, 16'd100, 16'd10, 16'd20);
      send_header(1'b0, 3'd7, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_data(8'h08);
      send_data(8'hF7);
      send_data(8'h00);
      send_header(1'b0, 3'd2, 16'd0, 16'hFFFF, 16'h0001);
      send_data(8'h7F);
      settle();

      // stereo, header-only block
      set_mode(1'b1, 16'd2);
      send_header(1'b0, 3'd1, 16'd100, 16'h8000, 16'h7FFF);
      send_header(1'b1, 3'd5, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_data(8'hC3);
      settle();

      set_mode(1'b1, 16'hFFFF);
      send_header(1'b0, 3'd6, 16'd16, 16'd300, 16'hFF00);
      send_header(1'b1, 3'd3, 16'd2000, 16'hF000, 16'd4000);
      send_data(8'h80);
      send_data(8'h8F);
      send_data(8'hFF);
      settle();

      // hold off the sample side long enough to back up the input
      set_mode(1'b0, 16'hFFFF);
      hold_armed = 1'b1;
      send_random_header(1'b0);
      repeat (30) send_data(8'($urandom));
      settle();

      while (tracker.decoded_items < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       set_mode(1'($urandom), 16'd2);
            1:       set_mode(1'($urandom), 16'd3);
            2:       set_mode(1'($urandom), 16'hFFFF);
            default: set_mode(1'($urandom), 16'($urandom_range(4, 48)));
         endcase
         req_idle_pct = 30 * $urandom_range(0, 2);
         rsp_idle_pct = 30 * $urandom_range(0, 2);
         repeat ($urandom_range(2, 5))
            if (tracker.decoded_items < ITEM_TARGET) run_block();
         settle();
      end

      if (tracker.bad_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
